>>> src/depth_pixel_backprojection_unit_macros.svh
// Assertion macros shared by the back-projection unit RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dpb_pkg.sv
// Shared types and constants of the depth pixel back-projection unit.
package dpb_pkg;

    localparam int CNT_W           = 12;
    localparam int COUNTER_LIMIT   = 4096;
    localparam int SIZE_W          = 13;
    localparam int PIX_W           = 16;
    localparam int COLOR_W         = 8;
    localparam int DEC_W           = 5;
    localparam int DEC_MAX         = 16;
    localparam int COORD_W         = 32;
    localparam int PROD_W          = 32;
    localparam int MOD_STEPS       = CNT_W;
    localparam int PROJ_STEPS      = PROD_W;
    localparam int STEP_W          = $clog2(PROJ_STEPS + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int MAX_ROWS_DEF    = 4096;

    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = SIZE_W'(480);
    localparam logic [PIX_W-1:0]  CENTER_X_RST     = PIX_W'(5120);
    localparam logic [PIX_W-1:0]  CENTER_Y_RST     = PIX_W'(3840);
    localparam logic [PIX_W-1:0]  FOCAL_X_RST      = PIX_W'(8192);
    localparam logic [PIX_W-1:0]  FOCAL_Y_RST      = PIX_W'(8192);
    localparam logic [PIX_W-1:0]  MAX_RANGE_RST    = PIX_W'(4000);
    localparam logic [DEC_W-1:0]  DECIMATION_RST   = DEC_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_FOCAL_X      = 3'd4,
        CFG_FOCAL_Y      = 3'd5,
        CFG_MAX_RANGE    = 3'd6,
        CFG_DECIMATION   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_COL_MOD,
        DIV_ROW_MOD,
        DIV_PROJ
    } div_sel_t;

    typedef enum logic {
        AXIS_X,
        AXIS_Y
    } axis_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [PIX_W-1:0]  center_x;
        logic [PIX_W-1:0]  center_y;
        logic [PIX_W-1:0]  focal_x;
        logic [PIX_W-1:0]  focal_y;
        logic [PIX_W-1:0]  max_range;
        logic [DEC_W-1:0]  decimation;
    } cfg_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_sel_t div_sel;
        axis_t    axis;
        logic     mul_load;
        logic     store_x;
        logic     store_y;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic pre_keep;
        logic div_done;
        logic rem_zero;
        logic out_free;
    } status_t;

endpackage

>>> src/dpb_cfg_regs.sv
// Configuration register file of the back-projection unit.
module dpb_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  dpb_pkg::cfg_idx_t             cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
    output dpb_pkg::cfg_t                 cfg
);
    import dpb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[SIZE_W-1:0];
                CFG_CENTER_X:     cfg_next.center_x     = cfg_data[PIX_W-1:0];
                CFG_CENTER_Y:     cfg_next.center_y     = cfg_data[PIX_W-1:0];
                CFG_FOCAL_X:      cfg_next.focal_x      = cfg_data[PIX_W-1:0];
                CFG_FOCAL_Y:      cfg_next.focal_y      = cfg_data[PIX_W-1:0];
                CFG_MAX_RANGE:    cfg_next.max_range    = cfg_data[PIX_W-1:0];
                CFG_DECIMATION:   cfg_next.decimation   = cfg_data[DEC_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.center_x     <= CENTER_X_RST;
            cfg_reg.center_y     <= CENTER_Y_RST;
            cfg_reg.focal_x      <= FOCAL_X_RST;
            cfg_reg.focal_y      <= FOCAL_Y_RST;
            cfg_reg.max_range    <= MAX_RANGE_RST;
            cfg_reg.decimation   <= DECIMATION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/dpb_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, left-aligned dividend.
`include "depth_pixel_backprojection_unit_macros.svh"

module dpb_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dpb_pkg::PROD_W-1:0]  numerator,
    input  logic [dpb_pkg::PIX_W-1:0]   divisor,
    input  logic [dpb_pkg::STEP_W-1:0]  steps,
    output logic                        done,
    output logic [dpb_pkg::PROD_W-1:0]  quotient,
    output logic [dpb_pkg::PIX_W-1:0]   remainder
);
    import dpb_pkg::*;

    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [PIX_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [PIX_W:0]    trial;
    logic              fits;
    logic [PIX_W:0]    diff;
    logic [PIX_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[PROD_W-1]};
        fits     = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[PROD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `DPB_ASSERT_SAME(a_div_no_restart, start, !busy_reg, "divider started while busy")
    `DPB_ASSERT_SAME(a_div_done_idle, done_reg, !busy_reg, "divider done while still busy")

endmodule

>>> src/dpb_datapath.sv
// Datapath: pixel counters, item registers, multiplier, divider and result beat.
module dpb_datapath #(
    parameter int MAX_COLUMNS = dpb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = dpb_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpb_pkg::cmd_t                 cmd,
    output dpb_pkg::status_t              status,
    input  dpb_pkg::cfg_t                 cfg,
    input  logic                          frame_start,
    input  logic [dpb_pkg::PIX_W-1:0]     depth_mm,
    input  logic [dpb_pkg::COLOR_W-1:0]   red,
    input  logic [dpb_pkg::COLOR_W-1:0]   green,
    input  logic [dpb_pkg::COLOR_W-1:0]   blue,
    input  logic [dpb_pkg::COLOR_W-1:0]   class_label,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dpb_pkg::PIX_W-1:0]     forward_mm,
    output logic signed [dpb_pkg::COORD_W-1:0] left_mm,
    output logic signed [dpb_pkg::COORD_W-1:0] up_mm,
    output logic [dpb_pkg::COLOR_W-1:0]   point_red,
    output logic [dpb_pkg::COLOR_W-1:0]   point_green,
    output logic [dpb_pkg::COLOR_W-1:0]   point_blue,
    output logic [dpb_pkg::COLOR_W-1:0]   point_label
);
    import dpb_pkg::*;

    localparam int COL_TOP = MAX_COLUMNS < COUNTER_LIMIT ? MAX_COLUMNS : COUNTER_LIMIT;
    localparam int ROW_TOP = MAX_ROWS < COUNTER_LIMIT ? MAX_ROWS : COUNTER_LIMIT;
    localparam logic [SIZE_W-1:0] COL_TOP_W = SIZE_W'(COL_TOP);
    localparam logic [SIZE_W-1:0] ROW_TOP_W = SIZE_W'(ROW_TOP);
    localparam logic [CNT_W-1:0]  ROW_LAST  = CNT_W'(COUNTER_LIMIT - 1);
    localparam logic [COORD_W-1:0] INT_MIN_W = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] INT_MAX_W = {1'b0, {(COORD_W-1){1'b1}}};

    // effective configuration
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [DEC_W-1:0]  d_eff;
    logic [PIX_W-1:0]  fx_eff;
    logic [PIX_W-1:0]  fy_eff;

    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = SIZE_W'(1);
        else if (cfg.image_width > COL_TOP_W)
            w_eff = COL_TOP_W;
        else
            w_eff = cfg.image_width;

        if (cfg.image_height == '0)
            h_eff = SIZE_W'(1);
        else if (cfg.image_height > ROW_TOP_W)
            h_eff = ROW_TOP_W;
        else
            h_eff = cfg.image_height;

        if (cfg.decimation == '0)
            d_eff = DEC_W'(1);
        else if (cfg.decimation > DEC_W'(DEC_MAX))
            d_eff = DEC_W'(DEC_MAX);
        else
            d_eff = cfg.decimation;

        fx_eff = (cfg.focal_x == '0) ? PIX_W'(1) : cfg.focal_x;
        fy_eff = (cfg.focal_y == '0) ? PIX_W'(1) : cfg.focal_y;
    end

    // raster counters
    logic [CNT_W-1:0]  col_cnt_reg;
    logic [CNT_W-1:0]  row_cnt_reg;
    logic [CNT_W-1:0]  col_cnt_next;
    logic [CNT_W-1:0]  row_cnt_next;
    logic [CNT_W-1:0]  col_cur;
    logic [CNT_W-1:0]  row_cur;
    logic [SIZE_W-1:0] col_inc;

    always_comb
    begin
        col_cur = frame_start ? '0 : col_cnt_reg;
        row_cur = frame_start ? '0 : row_cnt_reg;
        col_inc = SIZE_W'(col_cur) + SIZE_W'(1);
        if (col_inc < w_eff)
        begin
            col_cnt_next = col_inc[CNT_W-1:0];
            row_cnt_next = row_cur;
        end
        else
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_cur != ROW_LAST) ? row_cur + CNT_W'(1) : row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // item registers
    logic [CNT_W-1:0]   col_item_reg;
    logic [CNT_W-1:0]   row_item_reg;
    logic [PIX_W-1:0]   depth_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic [COLOR_W-1:0] label_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_item_reg <= col_cur;
            row_item_reg <= row_cur;
            depth_reg    <= depth_mm;
            red_reg      <= red;
            green_reg    <= green;
            blue_reg     <= blue;
            label_reg    <= class_label;
        end
    end

    // depth and grid bounds; col + d <= w stands for col/d < w/d on the grid
    logic [SIZE_W-1:0] col_end;
    logic [SIZE_W-1:0] row_end;

    always_comb
    begin
        col_end = SIZE_W'(col_item_reg) + SIZE_W'(d_eff);
        row_end = SIZE_W'(row_item_reg) + SIZE_W'(d_eff);
    end

    // product |16*pos - center| * depth, sign kept aside
    logic [CNT_W-1:0]  mul_pos;
    logic [PIX_W-1:0]  mul_center;
    logic [PIX_W:0]    mul_diff;
    logic [PIX_W-1:0]  mul_mag;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_neg_reg;

    always_comb
    begin
        mul_pos    = (cmd.axis == AXIS_X) ? col_item_reg : row_item_reg;
        mul_center = (cmd.axis == AXIS_X) ? cfg.center_x : cfg.center_y;
        mul_diff   = {1'b0, mul_pos, 4'b0000} - {1'b0, mul_center};
        mul_mag    = mul_diff[PIX_W] ? PIX_W'(-mul_diff) : mul_diff[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg     <= PROD_W'(mul_mag) * PROD_W'(depth_reg);
            prod_neg_reg <= mul_diff[PIX_W];
        end
    end

    // shared divider
    logic [PROD_W-1:0] div_num;
    logic [PIX_W-1:0]  div_den;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;
    logic [PIX_W-1:0]  div_rem;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_COL_MOD:
            begin
                div_num   = {col_item_reg, {(PROD_W-CNT_W){1'b0}}};
                div_den   = PIX_W'(d_eff);
                div_steps = STEP_W'(MOD_STEPS);
            end
            DIV_ROW_MOD:
            begin
                div_num   = {row_item_reg, {(PROD_W-CNT_W){1'b0}}};
                div_den   = PIX_W'(d_eff);
                div_steps = STEP_W'(MOD_STEPS);
            end
            DIV_PROJ:
            begin
                div_num   = prod_reg;
                div_den   = (cmd.axis == AXIS_X) ? fx_eff : fy_eff;
                div_steps = STEP_W'(PROJ_STEPS);
            end
            default:
            begin
                div_num   = prod_reg;
                div_den   = fx_eff;
                div_steps = STEP_W'(PROJ_STEPS);
            end
        endcase
    end

    dpb_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // give the quotient magnitude the sign opposite to the difference, saturated to signed 32 bits
    function automatic logic [COORD_W-1:0] negate_sat(input logic [PROD_W-1:0] q,
                                                      input logic diff_neg);
        logic [COORD_W-1:0] r;
        begin
            if (!diff_neg)
                r = (q > INT_MIN_W) ? INT_MIN_W : COORD_W'(~q + PROD_W'(1));
            else
                r = (q > INT_MAX_W) ? INT_MAX_W : COORD_W'(q);
            return r;
        end
    endfunction

    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] up_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store_x)
            left_reg <= negate_sat(div_quo, prod_neg_reg);
        if (cmd.store_y)
            up_reg <= negate_sat(div_quo, prod_neg_reg);
    end

    // result beat register
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_fwd_reg;
    logic [COORD_W-1:0] out_left_reg;
    logic [COORD_W-1:0] out_up_reg;
    logic [COLOR_W-1:0] out_red_reg;
    logic [COLOR_W-1:0] out_green_reg;
    logic [COLOR_W-1:0] out_blue_reg;
    logic [COLOR_W-1:0] out_label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_fwd_reg   <= depth_reg;
            out_left_reg  <= left_reg;
            out_up_reg    <= up_reg;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_label_reg <= label_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign forward_mm  = out_fwd_reg;
    assign left_mm     = $signed(out_left_reg);
    assign up_mm       = $signed(out_up_reg);
    assign point_red   = out_red_reg;
    assign point_green = out_green_reg;
    assign point_blue  = out_blue_reg;
    assign point_label = out_label_reg;

    always_comb
    begin
        status.pre_keep = (depth_reg != '0) && (depth_reg <= cfg.max_range)
                          && (col_end <= w_eff) && (row_end <= h_eff);
        status.div_done = div_done;
        status.rem_zero = (div_rem == '0);
        status.out_free = !out_valid_reg || !out_stall;
    end

endmodule

>>> src/dpb_ctrl.sv
// Sequencer: grid checks, two projections through the shared divider, result beat.
`include "depth_pixel_backprojection_unit_macros.svh"

module dpb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dpb_pkg::status_t   status,
    output dpb_pkg::cmd_t      cmd
);
    import dpb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MOD_COL,
        S_MOD_ROW,
        S_MUL_X,
        S_DIV_X,
        S_MUL_Y,
        S_DIV_Y,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_PROJ;
        cmd.axis      = AXIS_X;
        cmd.mul_load  = 1'b0;
        cmd.store_x   = 1'b0;
        cmd.store_y   = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.pre_keep)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_COL_MOD;
                    state_next    = S_MOD_COL;
                end
                else
                    state_next = S_IDLE;
            end
            S_MOD_COL:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_ROW_MOD;
                        state_next    = S_MOD_ROW;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_MOD_ROW:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.mul_load = 1'b1;
                        cmd.axis     = AXIS_X;
                        state_next   = S_MUL_X;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_MUL_X:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PROJ;
                cmd.axis      = AXIS_X;
                state_next    = S_DIV_X;
            end
            S_DIV_X:
            begin
                if (status.div_done)
                begin
                    cmd.store_x  = 1'b1;
                    cmd.mul_load = 1'b1;
                    cmd.axis     = AXIS_Y;
                    state_next   = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PROJ;
                cmd.axis      = AXIS_Y;
                state_next    = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (status.div_done)
                begin
                    cmd.store_y = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    `DPB_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "no stall after input beat")
    `DPB_ASSERT_SAME(a_done_in_wait, status.div_done, (state_reg == S_MOD_COL) || (state_reg == S_MOD_ROW) || (state_reg == S_DIV_X) || (state_reg == S_DIV_Y), "divider done outside a wait state")
    `DPB_ASSERT_SAME(a_out_slot_free, cmd.out_load, status.out_free, "result loaded over a held beat")

endmodule

>>> src/depth_pixel_backprojection_unit.sv
// Top level of the depth pixel back-projection unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall  | frame_start depth_mm red green blue label
//  out     | source    | out_valid/ out_stall | forward_mm left_mm up_mm point_* colors
//  cfg     | sink      | cfg_write_en         | cfg_index cfg_data
//
// One pixel at a time. A pixel is dropped on depth or grid bounds, or off the decimation
// grid after its column or row remainder pass; a kept pixel takes two 12-step remainder
// passes and two 32-step quotient passes through the one radix-2 divider.
// A finished point sits in the output register; the next pixel is taken while it waits.
// Reset presets counters, configuration and the sequencer; no clearing pass is needed.
module depth_pixel_backprojection_unit #(
    parameter int MAX_COLUMNS = dpb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = dpb_pkg::MAX_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               frame_start,
    input  logic [dpb_pkg::PIX_W-1:0]          depth_mm,
    input  logic [dpb_pkg::COLOR_W-1:0]        red,
    input  logic [dpb_pkg::COLOR_W-1:0]        green,
    input  logic [dpb_pkg::COLOR_W-1:0]        blue,
    input  logic [dpb_pkg::COLOR_W-1:0]        class_label,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dpb_pkg::PIX_W-1:0]          forward_mm,
    output logic signed [dpb_pkg::COORD_W-1:0] left_mm,
    output logic signed [dpb_pkg::COORD_W-1:0] up_mm,
    output logic [dpb_pkg::COLOR_W-1:0]        point_red,
    output logic [dpb_pkg::COLOR_W-1:0]        point_green,
    output logic [dpb_pkg::COLOR_W-1:0]        point_blue,
    output logic [dpb_pkg::COLOR_W-1:0]        point_label,
    input  logic                               cfg_write_en,
    input  dpb_pkg::cfg_idx_t                  cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dpb_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    dpb_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    dpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dpb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .frame_start (frame_start),
        .depth_mm    (depth_mm),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .class_label (class_label),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .forward_mm  (forward_mm),
        .left_mm     (left_mm),
        .up_mm       (up_mm),
        .point_red   (point_red),
        .point_green (point_green),
        .point_blue  (point_blue),
        .point_label (point_label)
    );

endmodule

>>> test/tb_depth_pixel_backprojection_unit.sv
// Self-checking testbench for the depth pixel back-projection unit.
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_unit;
    import dpb_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PIXELS = 490;
    localparam int SWEEP_ROWS    = 24;
    localparam int SWEEP_HEIGHT  = 16;

    typedef struct packed {
        logic               frame_start;
        logic [PIX_W-1:0]   depth;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] label;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]          forward;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] up;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [COLOR_W-1:0]        label;
    } point_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_NO_POINT,
        ROW_GIVEN
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        pixel_t                pix;
        point_t                given;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      frame_start;
    logic [PIX_W-1:0]          depth_mm;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        class_label;
    logic                      out_valid;
    logic                      out_stall;
    logic [PIX_W-1:0]          forward_mm;
    logic signed [COORD_W-1:0] left_mm;
    logic signed [COORD_W-1:0] up_mm;
    logic [COLOR_W-1:0]        point_red;
    logic [COLOR_W-1:0]        point_green;
    logic [COLOR_W-1:0]        point_blue;
    logic [COLOR_W-1:0]        point_label;
    logic                      cfg_write_en;
    cfg_idx_t                  cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    cfg_t             shadow_cfg;
    logic [CNT_W-1:0] col_pos;
    logic [CNT_W-1:0] row_pos;
    point_t           pending_points[$];
    point_t           due_point;
    point_t           blank_point;
    stim_row_t        stim_table[$];
    int               mismatch_count;
    int               random_pixels;
    int               idle_cycles;
    int               stall_len;
    bit               sender_quiet;
    bit               receiver_quiet;
    bit               hold_request;

    depth_pixel_backprojection_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (frame_start),
        .depth_mm    (depth_mm),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .class_label (class_label),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .forward_mm  (forward_mm),
        .left_mm     (left_mm),
        .up_mm       (up_mm),
        .point_red   (point_red),
        .point_green (point_green),
        .point_blue  (point_blue),
        .point_label (point_label),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  shadow_cfg.image_width  = data[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT: shadow_cfg.image_height = data[SIZE_W-1:0];
            CFG_CENTER_X:     shadow_cfg.center_x     = data;
            CFG_CENTER_Y:     shadow_cfg.center_y     = data;
            CFG_FOCAL_X:      shadow_cfg.focal_x      = data;
            CFG_FOCAL_Y:      shadow_cfg.focal_y      = data;
            CFG_MAX_RANGE:    shadow_cfg.max_range    = data;
            CFG_DECIMATION:   shadow_cfg.decimation   = data[DEC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int clamp_size(int v);
        if (v < 1)
            return 1;
        if (v > COUNTER_LIMIT)
            return COUNTER_LIMIT;
        return v;
    endfunction

    // -trunc((16*pos - center) * depth / focal), saturated to 32 bits
    function automatic logic signed [COORD_W-1:0] back_project(int pos,
        logic [PIX_W-1:0] center, logic [PIX_W-1:0] depth, logic [PIX_W-1:0] focal);
        longint diff;
        longint divisor;
        longint quot;
        diff = longint'(pos) * 16 - longint'(center);
        divisor = (focal == '0) ? 64'sd1 : longint'(focal);
        quot = -((diff * longint'(depth)) / divisor);
        if (quot > 64'sd2147483647)
            quot = 64'sd2147483647;
        if (quot < -64'sd2147483648)
            quot = -64'sd2147483648;
        return quot[COORD_W-1:0];
    endfunction

    function automatic bit project_pixel(pixel_t px, output point_t pt);
        int  w;
        int  h;
        int  d;
        int  col;
        int  row;
        bit  keep;
        w = clamp_size(int'(shadow_cfg.image_width));
        h = clamp_size(int'(shadow_cfg.image_height));
        d = int'(shadow_cfg.decimation);
        if (d < 1)
            d = 1;
        if (d > DEC_MAX)
            d = DEC_MAX;
        if (px.frame_start)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        col = int'(col_pos);
        row = int'(row_pos);
        keep = (col < w) && (row < h) && (col % d == 0) && (row % d == 0)
            && (col / d < w / d) && (row / d < h / d)
            && (px.depth != '0) && (int'(px.depth) <= int'(shadow_cfg.max_range));
        pt.forward = px.depth;
        pt.left    = back_project(col, shadow_cfg.center_x, px.depth, shadow_cfg.focal_x);
        pt.up      = back_project(row, shadow_cfg.center_y, px.depth, shadow_cfg.focal_y);
        pt.red     = px.red;
        pt.green   = px.green;
        pt.blue    = px.blue;
        pt.label   = px.label;
        if (col + 1 < w)
            col_pos = CNT_W'(col + 1);
        else
        begin
            col_pos = '0;
            if (row < COUNTER_LIMIT - 1)
                row_pos = CNT_W'(row + 1);
        end
        return keep;
    endfunction

    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = $urandom_range(1, 24);
        else if (r < 80)
            v = $urandom_range(25, 700);
        else if (r < 88)
            v = COUNTER_LIMIT;
        else if (r < 94)
            v = $urandom_range(COUNTER_LIMIT + 1, 8191);
        else
            v = 0;
        return {3'($urandom_range(0, 7)), 13'(v)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_decimation();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 60)
            v = $urandom_range(1, 4);
        else if (r < 75)
            v = $urandom_range(5, DEC_MAX);
        else if (r < 85)
            v = 0;
        else
            v = $urandom_range(DEC_MAX + 1, 31);
        return {11'($urandom), 5'(v)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return '1;
        if (r < 60)
            return 16'($urandom_range(0, 400));
        return 16'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_focal();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return 16'd1;
        if (r < 30)
            return '1;
        return 16'($urandom_range(16, 16384));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_range();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 15)
            return '1;
        return 16'($urandom_range(500, 65535));
    endfunction

    function automatic logic [PIX_W-1:0] pick_depth(logic [PIX_W-1:0] limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 30 || limit == '0)
            return 16'($urandom);
        return 16'($urandom_range(1, int'(limit)));
    endfunction

    function automatic pixel_t random_pixel(logic start, logic [PIX_W-1:0] depth);
        pixel_t px;
        px.frame_start = start;
        px.depth       = depth;
        px.red         = 8'($urandom);
        px.green       = 8'($urandom);
        px.blue        = 8'($urandom);
        px.label       = 8'($urandom);
        return px;
    endfunction

    function automatic void add_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.pix      = '0;
        row.given    = '0;
        stim_table = {stim_table, row};
    endfunction

    function automatic void add_pixel(row_kind_t kind, logic start, logic [PIX_W-1:0] depth,
        logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] l,
        logic signed [COORD_W-1:0] lft = 0, logic signed [COORD_W-1:0] upv = 0);
        stim_row_t row;
        row.kind              = kind;
        row.reg_idx           = CFG_IMAGE_WIDTH;
        row.reg_data          = '0;
        row.pix.frame_start   = start;
        row.pix.depth         = depth;
        row.pix.red           = r;
        row.pix.green         = g;
        row.pix.blue          = b;
        row.pix.label         = l;
        row.given.forward     = depth;
        row.given.left        = lft;
        row.given.up          = upv;
        row.given.red         = r;
        row.given.green       = g;
        row.given.blue        = b;
        row.given.label       = l;
        stim_table = {stim_table, row};
    endfunction

    function automatic void build_table();
        // reset setting: 640x480, center at mid image, focal 512 px, range 4 m, every 4th
        add_pixel(ROW_GIVEN, 1, 16'd1000, 8'hFF, 8'h00, 8'hFF, 8'h00, 625, 468);
        add_pixel(ROW_NO_POINT, 0, 16'd1000, 8'h11, 8'h22, 8'h33, 8'h44);
        add_pixel(ROW_NO_POINT, 1, 16'd0, 8'h55, 8'h66, 8'h77, 8'h88);
        add_pixel(ROW_NO_POINT, 1, 16'd4001, 8'h99, 8'hAA, 8'hBB, 8'hCC);
        add_pixel(ROW_GIVEN, 1, 16'd4000, 8'h00, 8'hFF, 8'h00, 8'hFF, 2500, 1875);
        add_pixel(ROW_NO_POINT, 0, 16'd4000, 8'h01, 8'h02, 8'h04, 8'h08);
        add_pixel(ROW_NO_POINT, 0, 16'd123, 8'h10, 8'h20, 8'h40, 8'h80);
        add_pixel(ROW_NO_POINT, 0, 16'd1, 8'hFE, 8'hFD, 8'hFB, 8'hF7);
        add_pixel(ROW_PREDICT, 0, 16'd3999, 8'hEF, 8'hDF, 8'hBF, 8'h7F);
        add_pixel(ROW_NO_POINT, 1, 16'hFFFF, 8'h12, 8'h34, 8'h56, 8'h78);
        // focal zero, decimation zero, full range, centers at the extremes
        add_cfg(CFG_MAX_RANGE, 16'hFFFF);
        add_cfg(CFG_CENTER_X, 16'h0000);
        add_cfg(CFG_CENTER_Y, 16'hFFFF);
        add_cfg(CFG_FOCAL_X, 16'h0000);
        add_cfg(CFG_FOCAL_Y, 16'h0001);
        add_cfg(CFG_DECIMATION, 16'h0000);
        add_pixel(ROW_GIVEN, 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 32'sh7FFFFFFF);
        add_pixel(ROW_PREDICT, 0, 16'hFFFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        add_pixel(ROW_PREDICT, 0, 16'd7, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        // oversize width, zero height, decimation above 16: nothing fits the grid
        add_cfg(CFG_IMAGE_WIDTH, 16'h1FFF);
        add_cfg(CFG_IMAGE_HEIGHT, 16'hE000);
        add_cfg(CFG_DECIMATION, 16'hFFFF);
        add_cfg(CFG_CENTER_X, 16'hFFFF);
        add_cfg(CFG_FOCAL_X, 16'h0001);
        add_pixel(ROW_NO_POINT, 1, 16'd500, 8'h13, 8'h57, 8'h9B, 8'hDF);
        add_cfg(CFG_DECIMATION, 16'h0001);
        add_pixel(ROW_PREDICT, 1, 16'hFFFF, 8'h24, 8'h68, 8'hAC, 8'hE0);
        add_pixel(ROW_PREDICT, 0, 16'hFFFF, 8'h31, 8'h75, 8'hB9, 8'hFD);
        add_pixel(ROW_PREDICT, 0, 16'd2, 8'h42, 8'h86, 8'hCA, 8'h0E);
        add_pixel(ROW_NO_POINT, 0, 16'd0, 8'h53, 8'h97, 8'hDB, 8'h1F);
        // shrink width mid-frame: column past the new width wraps
        add_cfg(CFG_IMAGE_WIDTH, 16'd2);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd4);
        add_pixel(ROW_NO_POINT, 0, 16'd100, 8'h64, 8'hA8, 8'hEC, 8'h20);
        add_pixel(ROW_PREDICT, 0, 16'd100, 8'h75, 8'hB9, 8'hFD, 8'h31);
        add_pixel(ROW_PREDICT, 0, 16'd200, 8'h86, 8'hCA, 8'h0E, 8'h42);
        add_pixel(ROW_PREDICT, 0, 16'd300, 8'h97, 8'hDB, 8'h1F, 8'h53);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_pixel(pixel_t px, row_kind_t kind, point_t given);
        point_t pt;
        bit     kept;
        int     gap;
        gap = idle_len(sender_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_start <= px.frame_start;
        depth_mm    <= px.depth;
        red         <= px.red;
        green       <= px.green;
        blue        <= px.blue;
        class_label <= px.label;
        do
            @(posedge clk);
        while (in_stall);
        kept = project_pixel(px, pt);
        if (kind == ROW_GIVEN)
            pending_points = {pending_points, given};
        else if (kind == ROW_PREDICT && kept)
            pending_points = {pending_points, pt};
        @(negedge clk);
    endtask

    task automatic drain_points();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        load_reg(idx, data);
    endtask

    task automatic run_frame_phase(bit pressure);
        pixel_t px;
        int     n_pixels;
        drain_points();
        sender_quiet   = pressure || ($urandom_range(0, 4) == 0);
        receiver_quiet = ($urandom_range(0, 4) == 0);
        write_reg(CFG_IMAGE_WIDTH, pressure ? 16'd8 : pick_size());
        write_reg(CFG_IMAGE_HEIGHT, pressure ? 16'd8 : pick_size());
        write_reg(CFG_CENTER_X, pick_center());
        write_reg(CFG_CENTER_Y, pick_center());
        write_reg(CFG_FOCAL_X, pick_focal());
        write_reg(CFG_FOCAL_Y, pick_focal());
        write_reg(CFG_MAX_RANGE, pressure ? 16'hFFFF : pick_range());
        write_reg(CFG_DECIMATION, pressure ? 16'd1 : pick_decimation());
        cfg_write_en <= 1'b0;
        if (pressure)
            hold_request = 1'b1;
        n_pixels = $urandom_range(20, 60);
        for (int i = 0; i < n_pixels; i++)
        begin
            px = random_pixel((i == 0) ? 1'($urandom_range(0, 1))
                                       : 1'($urandom_range(0, 49) == 0),
                              pick_depth(shadow_cfg.max_range));
            send_pixel(px, ROW_PREDICT, blank_point);
            random_pixels++;
        end
    endtask

    // one column: rows run past the image height, those pixels give no point
    task automatic run_row_sweep();
        drain_points();
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'(SWEEP_HEIGHT));
        write_reg(CFG_CENTER_X, 16'd0);
        write_reg(CFG_CENTER_Y, 16'd0);
        write_reg(CFG_FOCAL_X, 16'd1);
        write_reg(CFG_FOCAL_Y, 16'd1);
        write_reg(CFG_MAX_RANGE, 16'hFFFF);
        write_reg(CFG_DECIMATION, 16'd1);
        cfg_write_en <= 1'b0;
        for (int r = 0; r < SWEEP_ROWS; r++)
            send_pixel(random_pixel(r == 0, 16'($urandom)), ROW_PREDICT, blank_point);
        send_pixel(random_pixel(1'b0, 16'hFFFF), ROW_PREDICT, blank_point);
        send_pixel(random_pixel(1'b0, 16'd1), ROW_PREDICT, blank_point);
        for (int r = 0; r < 3; r++)
            send_pixel(random_pixel(1'b0, 16'($urandom)), ROW_PREDICT, blank_point);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                stall_len = idle_len(receiver_quiet);
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected point beat: forward_mm %0d", forward_mm);
                mismatch_count++;
            end
            else
            begin
                due_point = pending_points.pop_front();
                if (forward_mm !== due_point.forward)
                begin
                    $error("forward_mm: expected %0d, got %0d", due_point.forward, forward_mm);
                    mismatch_count++;
                end
                if (left_mm !== due_point.left)
                begin
                    $error("left_mm: expected %0d, got %0d", due_point.left, left_mm);
                    mismatch_count++;
                end
                if (up_mm !== due_point.up)
                begin
                    $error("up_mm: expected %0d, got %0d", due_point.up, up_mm);
                    mismatch_count++;
                end
                if (point_red !== due_point.red)
                begin
                    $error("point_red: expected %0d, got %0d", due_point.red, point_red);
                    mismatch_count++;
                end
                if (point_green !== due_point.green)
                begin
                    $error("point_green: expected %0d, got %0d", due_point.green, point_green);
                    mismatch_count++;
                end
                if (point_blue !== due_point.blue)
                begin
                    $error("point_blue: expected %0d, got %0d", due_point.blue, point_blue);
                    mismatch_count++;
                end
                if (point_label !== due_point.label)
                begin
                    $error("point_label: expected %0d, got %0d", due_point.label, point_label);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        bit cfg_open;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        frame_start  = 1'b0;
        depth_mm     = '0;
        red          = '0;
        green        = '0;
        blue         = '0;
        class_label  = '0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        idle_cycles     = 0;
        mismatch_count  = 0;
        random_pixels   = 0;
        sender_quiet    = 1'b0;
        receiver_quiet  = 1'b0;
        hold_request    = 1'b0;
        blank_point     = '0;
        cfg_open        = 1'b0;
        shadow_cfg.image_width  = IMAGE_WIDTH_RST;
        shadow_cfg.image_height = IMAGE_HEIGHT_RST;
        shadow_cfg.center_x     = CENTER_X_RST;
        shadow_cfg.center_y     = CENTER_Y_RST;
        shadow_cfg.focal_x      = FOCAL_X_RST;
        shadow_cfg.focal_y      = FOCAL_Y_RST;
        shadow_cfg.max_range    = MAX_RANGE_RST;
        shadow_cfg.decimation   = DECIMATION_RST;
        col_pos = '0;
        row_pos = '0;
        build_table();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                begin
                    drain_points();
                    cfg_open = 1'b1;
                end
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_write_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_pixel(stim_table[i].pix, stim_table[i].kind, stim_table[i].given);
            end
        end

        phase = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            run_frame_phase(phase == 3);
            phase++;
        end
        run_row_sweep();
        drain_points();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
